/* src/smx_pkg.sv */
// Shared types and constants for the three-pass modular exponentiation block.
package smx_pkg;

  localparam int unsigned CfgIdxWidth = 2;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_MODULUS  = 2'd0,
    CFG_SEND_EXP = 2'd1,
    CFG_RECV_EXP = 2'd2
  } cfg_idx_e;

endpackage

/* src/smx_if.sv */
// Valid/ready channel interfaces for message and result beats.
interface smx_msg_if #(
  parameter int unsigned MOD_WIDTH = 16
);
  logic                 valid;
  logic                 ready;
  logic [MOD_WIDTH-1:0] message;

  modport source (output valid, output message, input ready);
  modport sink   (input valid, input message, output ready);
endinterface

interface smx_res_if #(
  parameter int unsigned MOD_WIDTH = 16
);
  logic                 valid;
  logic                 ready;
  logic [MOD_WIDTH-1:0] first_pass;
  logic [MOD_WIDTH-1:0] second_pass;
  logic [MOD_WIDTH-1:0] third_pass;
  logic [MOD_WIDTH-1:0] recovered;
  logic                 key_error;

  modport source (output valid, output first_pass, output second_pass, output third_pass,
                  output recovered, output key_error, input ready);
  modport sink   (input valid, input first_pass, input second_pass, input third_pass,
                  input recovered, input key_error, output ready);
endinterface

/* src/smx_modmul.sv */
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle.
module smx_modmul
  import smx_pkg::*;
#(
  parameter int unsigned MOD_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 go_i,
  input  logic [MOD_WIDTH-1:0] a_i,
  input  logic [MOD_WIDTH-1:0] b_i,
  input  logic [MOD_WIDTH-1:0] m_i,
  output logic                 done_o,
  output logic [MOD_WIDTH-1:0] p_o
);

  localparam int unsigned CntWidth = $clog2(MOD_WIDTH);

  logic [MOD_WIDTH-1:0] a_q, b_q, m_q, acc_q, acc_d;
  logic [CntWidth-1:0]  cnt_q;
  logic                 busy_q, done_q;
  logic [MOD_WIDTH:0]   dbl, dbl_r, sum, sum_r;

  always_comb begin
    dbl   = {acc_q, 1'b0};
    dbl_r = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
    sum   = dbl_r + {1'b0, b_q};
    sum_r = (sum >= {1'b0, m_q}) ? sum - {1'b0, m_q} : sum;
    acc_d = a_q[MOD_WIDTH-1] ? sum_r[MOD_WIDTH-1:0] : dbl_r[MOD_WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntWidth'(MOD_WIDTH - 1);
        a_q    <= a_i;
        b_q    <= b_i;
        m_q    <= m_i;
        acc_q  <= '0;
      end else if (busy_q) begin
        acc_q <= acc_d;
        a_q   <= {a_q[MOD_WIDTH-2:0], 1'b0};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

/* src/smx_divider.sv */
// Restoring divider, one quotient bit per cycle.
module smx_divider
  import smx_pkg::*;
#(
  parameter int unsigned MOD_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 go_i,
  input  logic [MOD_WIDTH-1:0] dividend_i,
  input  logic [MOD_WIDTH-1:0] divisor_i,
  output logic                 done_o,
  output logic [MOD_WIDTH-1:0] quot_o,
  output logic [MOD_WIDTH-1:0] rem_o
);

  localparam int unsigned CntWidth = $clog2(MOD_WIDTH);

  logic [MOD_WIDTH-1:0] q_q, d_q, r_q;
  logic [CntWidth-1:0]  cnt_q;
  logic                 busy_q, done_q;
  logic [MOD_WIDTH:0]   trial;
  logic                 fits;

  always_comb begin
    trial = {r_q, q_q[MOD_WIDTH-1]};
    fits  = trial >= {1'b0, d_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntWidth'(MOD_WIDTH - 1);
        q_q    <= dividend_i;
        d_q    <= divisor_i;
        r_q    <= '0;
      end else if (busy_q) begin
        r_q   <= fits ? MOD_WIDTH'(trial - {1'b0, d_q}) : trial[MOD_WIDTH-1:0];
        q_q   <= {q_q[MOD_WIDTH-2:0], fits};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o  = r_q;

endmodule

/* src/shamir_three_pass_modexp.sv */
// Shamir three-pass exchange: two modular inverses and four modular exponentiations per message.
// One message at a time; the input is ready only while the block is idle. Every modular multiply
// and every divide runs in a bit-serial unit. Each unlocking exponent costs one reduction divide,
// and then one divide and one multiply per extended Euclid round; the message reduction is one
// more divide. Each power costs one setup state (S_POW_INIT) plus MOD_WIDTH + ones products, ones
// being the set bits of its exponent. The run time of a message is set mostly by the exponent
// bits and the Euclid rounds. A bad key (no inverse, or modulus below 3) returns a key_error beat
// as soon as the inverse search fails; a modulus below 3 goes from accept straight to S_FIN. The
// result beat is registered and held until taken; a stalled result does not block the next
// message from being accepted, but holds that message's result in S_FIN.
module shamir_three_pass_modexp
  import smx_pkg::*;
#(
  parameter int unsigned MOD_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [MOD_WIDTH-1:0]   cfg_data_i,
  smx_msg_if.sink                in_s,
  smx_res_if.source              out_m
);

  localparam int unsigned BitWidth = $clog2(MOD_WIDTH);

  typedef enum logic [3:0] {
    S_IDLE, S_INV_RED, S_INV_CHK, S_INV_DIV, S_INV_MUL,
    S_MSG_RED, S_POW_INIT, S_POW_SQ, S_POW_MUL, S_FIN
  } state_e;

  state_e               state_q;
  logic [MOD_WIDTH-1:0] mod_q, se_q, re_q, da_q, db_q, msg_q;
  logic [MOD_WIDTH-1:0] r0_q, r1_q, rn_q, t0_q, t1_q;
  logic [MOD_WIDTH-1:0] base_q, exp_q;
  logic [MOD_WIDTH-1:0] vals_q [4];
  logic [1:0]           pidx_q;
  logic [BitWidth-1:0]  bit_q;
  logic                 inv_sel_q, err_q, out_valid_q;
  logic [MOD_WIDTH-1:0] mul_a_q, mul_b_q, mul_m_q, div_a_q, div_b_q;
  logic [MOD_WIDTH-1:0] mul_p, div_q, div_r, n_m1;
  logic                 mul_go_q, mul_go_d, mul_done, div_go_q, div_go_d, div_done;
  logic                 pow_bit_set;

  assign n_m1        = mod_q - 1'b1;
  assign pow_bit_set = (state_q == S_POW_SQ) && exp_q[bit_q];

  smx_modmul #(.MOD_WIDTH(MOD_WIDTH)) u_mul (
    .clk_i, .rst_ni, .go_i(mul_go_q), .a_i(mul_a_q), .b_i(mul_b_q), .m_i(mul_m_q),
    .done_o(mul_done), .p_o(mul_p)
  );

  smx_divider #(.MOD_WIDTH(MOD_WIDTH)) u_div (
    .clk_i, .rst_ni, .go_i(div_go_q), .dividend_i(div_a_q), .divisor_i(div_b_q),
    .done_o(div_done), .quot_o(div_q), .rem_o(div_r)
  );

  always_comb begin
    mul_go_d = 1'b0;
    div_go_d = 1'b0;
    case (state_q)
      S_IDLE:              div_go_d = in_s.valid && (mod_q >= MOD_WIDTH'(3));
      S_INV_CHK:           div_go_d = (r1_q != '0) || (r0_q == MOD_WIDTH'(1));
      S_INV_DIV:           mul_go_d = div_done;
      S_POW_INIT:          mul_go_d = 1'b1;
      S_POW_SQ, S_POW_MUL: mul_go_d = mul_done && (pow_bit_set || (bit_q != '0));
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      mul_go_q    <= 1'b0;
      div_go_q    <= 1'b0;
      mod_q       <= MOD_WIDTH'(257);
      se_q        <= MOD_WIDTH'(3);
      re_q        <= MOD_WIDTH'(5);
      err_q       <= 1'b0;
      inv_sel_q   <= 1'b0;
      pidx_q      <= '0;
    end else begin
      mul_go_q <= mul_go_d;
      div_go_q <= div_go_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MODULUS:  mod_q <= cfg_data_i;
          CFG_SEND_EXP: se_q  <= cfg_data_i;
          CFG_RECV_EXP: re_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && out_m.ready && state_q != S_FIN) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_s.valid) begin
            msg_q     <= in_s.message;
            inv_sel_q <= 1'b0;
            err_q     <= (mod_q < MOD_WIDTH'(3));
            div_a_q   <= se_q;
            div_b_q   <= n_m1;
            state_q   <= (mod_q < MOD_WIDTH'(3)) ? S_FIN : S_INV_RED;
          end
        end
        S_INV_RED: begin
          if (div_done) begin
            r0_q    <= n_m1;
            r1_q    <= div_r;
            t0_q    <= '0;
            t1_q    <= MOD_WIDTH'(1);
            state_q <= S_INV_CHK;
          end
        end
        S_INV_CHK: begin
          if (r1_q == '0) begin
            if (r0_q == MOD_WIDTH'(1)) begin
              if (!inv_sel_q) begin
                da_q      <= t0_q;
                inv_sel_q <= 1'b1;
                div_a_q   <= re_q;
                div_b_q   <= n_m1;
                state_q   <= S_INV_RED;
              end else begin
                db_q    <= t0_q;
                div_a_q <= msg_q;
                div_b_q <= mod_q;
                state_q <= S_MSG_RED;
              end
            end else begin
              err_q   <= 1'b1;
              state_q <= S_FIN;
            end
          end else begin
            div_a_q <= r0_q;
            div_b_q <= r1_q;
            state_q <= S_INV_DIV;
          end
        end
        S_INV_DIV: begin
          if (div_done) begin
            rn_q    <= div_r;
            mul_a_q <= div_q;
            mul_b_q <= t1_q;
            mul_m_q <= n_m1;
            state_q <= S_INV_MUL;
          end
        end
        S_INV_MUL: begin
          if (mul_done) begin
            t0_q    <= t1_q;
            t1_q    <= (t0_q >= mul_p) ? t0_q - mul_p : t0_q + (n_m1 - mul_p);
            r0_q    <= r1_q;
            r1_q    <= rn_q;
            state_q <= S_INV_CHK;
          end
        end
        S_MSG_RED: begin
          if (div_done) begin
            base_q  <= div_r;
            pidx_q  <= '0;
            state_q <= S_POW_INIT;
          end
        end
        S_POW_INIT: begin
          case (pidx_q)
            2'd0:    exp_q <= se_q;
            2'd1:    exp_q <= re_q;
            2'd2:    exp_q <= da_q;
            default: exp_q <= db_q;
          endcase
          bit_q   <= BitWidth'(MOD_WIDTH - 1);
          mul_a_q <= MOD_WIDTH'(1);
          mul_b_q <= MOD_WIDTH'(1);
          mul_m_q <= mod_q;
          state_q <= S_POW_SQ;
        end
        S_POW_SQ, S_POW_MUL: begin
          if (mul_done) begin
            if (pow_bit_set) begin
              mul_a_q <= mul_p;
              mul_b_q <= base_q;
              state_q <= S_POW_MUL;
            end else if (bit_q == '0) begin
              vals_q[pidx_q] <= mul_p;
              base_q         <= mul_p;
              pidx_q         <= pidx_q + 1'b1;
              state_q        <= (pidx_q == 2'd3) ? S_FIN : S_POW_INIT;
            end else begin
              bit_q   <= bit_q - 1'b1;
              mul_a_q <= mul_p;
              mul_b_q <= mul_p;
              state_q <= S_POW_SQ;
            end
          end
        end
        S_FIN: begin
          if (!out_valid_q || out_m.ready) begin
            out_m.first_pass  <= err_q ? '0 : vals_q[0];
            out_m.second_pass <= err_q ? '0 : vals_q[1];
            out_m.third_pass  <= err_q ? '0 : vals_q[2];
            out_m.recovered   <= err_q ? '0 : vals_q[3];
            out_m.key_error   <= err_q;
            out_valid_q       <= 1'b1;
            state_q           <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_s.ready  = (state_q == S_IDLE);
  assign out_m.valid = out_valid_q;

endmodule

/* src/smx_checker.sv */
// Port-level assertions for the three-pass block, bound to the top level.
module smx_checker #(
  parameter int unsigned MOD_WIDTH = 16
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [MOD_WIDTH-1:0] out_first_i,
  input logic [MOD_WIDTH-1:0] out_recov_i,
  input logic                 out_err_i
);

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_err_i |-> out_first_i == '0 && out_recov_i == '0)
    else $error("key error beat carries nonzero fields");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after an accepted beat");

  a_no_result_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !out_valid_i |=> !out_valid_i)
    else $error("result appeared in the cycle after accept");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_first_i))
    else $error("stalled result beat changed");

endmodule

bind shamir_three_pass_modexp smx_checker #(.MOD_WIDTH(MOD_WIDTH)) u_smx_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_valid_i(in_s.valid),
  .in_ready_i(in_s.ready),
  .out_valid_i(out_m.valid),
  .out_ready_i(out_m.ready),
  .out_first_i(out_m.first_pass),
  .out_recov_i(out_m.recovered),
  .out_err_i(out_m.key_error)
);
